[hdl/bvft_pkg.sv]
// Shared constants and types for the battery voltage filter with trend detection.
package bvft_pkg;

  localparam int unsigned MAX_SAMPLES = 16;
  localparam int unsigned TREND_SLOTS = 8;

  localparam int unsigned SMP_W  = 12;
  localparam int unsigned MV_W   = 14;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned DCNT_W = $clog2(SUM_W);
  localparam int unsigned FAC_W  = 3;
  localparam int unsigned THR_W  = 10;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned CDAT_W = 10;

  localparam logic [SMP_W-1:0] NOMINAL_FULL_MV = 12'd3100;
  localparam logic [SMP_W-1:0] FULL_CODE       = 12'd4095;
  localparam logic [MV_W-1:0]  MV_MAX          = 14'd16383;
  localparam logic [SUM_W-1:0] SUM_MAX         = 16'hFFFF;

  localparam logic [FAC_W-1:0] FACTOR_RST = 3'd3;
  localparam logic [THR_W-1:0] THRESH_RST = 10'd20;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_NOMINAL = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FACTOR  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_THRESH  = 2'd2;

  typedef struct packed {
    logic [SMP_W-1:0] sample_value;
    logic             sample_ok;
    logic             last_of_round;
    logic             trend_due;
  } smp_item_t;

  typedef struct packed {
    logic capture;
    logic mult;
    logic est;
    logic corr;
    logic accum;
    logic clr_round;
    logic div_start;
    logic div_step;
    logic batt;
    logic filt;
    logic push;
    logic read_old;
    logic cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic due;
    logic good_zero;
    logic div_last;
    logic ring_full;
    logic out_free;
  } status_t;

endpackage

[hdl/bvft_if.sv]
// Handshake channel interfaces: sample requests, results and configuration writes.
interface bvft_smp_if;
  logic                       valid;
  logic                       ready;
  logic [bvft_pkg::SMP_W-1:0] sample_value;
  logic                       sample_ok;
  logic                       last_of_round;
  logic                       trend_due;

  modport source (output valid, output sample_value, output sample_ok,
                  output last_of_round, output trend_due, input ready);
  modport sink   (input valid, input sample_value, input sample_ok,
                  input last_of_round, input trend_due, output ready);
endinterface

interface bvft_res_if;
  logic                      valid;
  logic                      ready;
  logic [bvft_pkg::MV_W-1:0] smooth_mv;
  logic                      charging;

  modport source (output valid, output smooth_mv, output charging, input ready);
  modport sink   (input valid, input smooth_mv, input charging, output ready);
endinterface

interface bvft_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bvft_pkg::CIDX_W-1:0] index;
  logic [bvft_pkg::CDAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/bvft_ctrl.sv]
// Sequencer for the filter: steps one request through scaling, averaging, filter and trend.
module bvft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bvft_pkg::status_t status_i,
  output bvft_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULT, S_EST, S_CORR, S_ACCUM, S_ENDR, S_DIV,
    S_BATT, S_FILT, S_PUSH, S_READ, S_CMP, S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MULT;
        end
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_EST;
      end
      S_EST: begin
        cmd_o.est = 1'b1;
        state_d   = S_CORR;
      end
      S_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = S_ACCUM;
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last ? S_ENDR : S_IDLE;
      end
      S_ENDR: begin
        if (status_i.good_zero) begin
          cmd_o.clr_round = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_BATT;
        end
      end
      S_BATT: begin
        cmd_o.batt = 1'b1;
        state_d    = S_FILT;
      end
      S_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = status_i.due ? S_PUSH : S_EMIT;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = status_i.ring_full ? S_READ : S_EMIT;
      end
      S_READ: begin
        cmd_o.read_old = 1'b1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hdl/bvft_dp.sv]
// Datapath: scaling, round sum, serial divider, filter, trend ring and result register.
module bvft_dp #(
  parameter int unsigned MAX_SAMPLES = bvft_pkg::MAX_SAMPLES,
  parameter int unsigned TREND_SLOTS = bvft_pkg::TREND_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bvft_pkg::smp_item_t           item_i,
  input  logic                          cfg_we_i,
  input  logic [bvft_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [bvft_pkg::CDAT_W-1:0]   cfg_data_i,
  input  bvft_pkg::cmd_t                cmd_i,
  output bvft_pkg::status_t             status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bvft_pkg::MV_W-1:0]     out_mv_o,
  output logic                          out_chg_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned HEAD_W = (TREND_SLOTS > 1) ? $clog2(TREND_SLOTS) : 1;
  localparam int unsigned FILL_W = $clog2(TREND_SLOTS + 1);
  localparam int unsigned SMP_W  = bvft_pkg::SMP_W;
  localparam int unsigned MV_W   = bvft_pkg::MV_W;
  localparam int unsigned SUM_W  = bvft_pkg::SUM_W;
  localparam int unsigned PROD_W = 2 * SMP_W;
  localparam int unsigned BATT_W = SUM_W + bvft_pkg::FAC_W;

  // configuration
  logic                        nominal_q;
  logic [bvft_pkg::FAC_W-1:0]  factor_q;
  logic [bvft_pkg::THR_W-1:0]  thresh_q;

  // request payload and per-sample pipeline
  logic [SMP_W-1:0]   sample_q;
  logic               ok_q, last_q, due_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SMP_W-1:0]   q0_q;
  logic [SMP_W-1:0]   mv_q;

  // round state
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   good_q, tries_q;

  // divider
  logic [CNT_W-1:0]   rem_q;
  logic [SUM_W-1:0]   quo_q;
  logic [bvft_pkg::DCNT_W-1:0] dcnt_q;

  // filter and trend
  logic [MV_W-1:0]    batt_q;
  logic [MV_W-1:0]    filt_q;
  logic               seeded_q;
  logic [MV_W-1:0]    ring_q [TREND_SLOTS];
  logic [HEAD_W-1:0]  head_q;
  logic [FILL_W-1:0]  fill_q;
  logic [MV_W-1:0]    oldest_q;
  logic               chg_q;

  // result register
  logic               out_valid_q;
  logic [MV_W-1:0]    out_mv_q;
  logic               out_chg_q;

  logic [PROD_W:0]    est_sum, corr_rem;
  logic [SUM_W:0]     sum_ext;
  logic [CNT_W:0]     div_shift;
  logic               div_ge;
  logic [BATT_W-1:0]  batt_prod;
  logic [MV_W+1:0]    filt_sum;
  logic [MV_W-1:0]    rise, fall;

  assign est_sum   = {1'b0, prod_q} + {{(SMP_W + 1){1'b0}}, prod_q[PROD_W-1:SMP_W]};
  assign corr_rem  = {1'b0, prod_q} - {1'b0, q0_q, {SMP_W{1'b0}}}
                     + {{(SMP_W + 1){1'b0}}, q0_q};
  assign sum_ext   = {1'b0, sum_q} + {{(SUM_W - SMP_W + 1){1'b0}}, mv_q};
  assign div_shift = {rem_q, quo_q[SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, good_q});
  assign batt_prod = {{bvft_pkg::FAC_W{1'b0}}, quo_q}
                     * {{SUM_W{1'b0}}, factor_q};
  assign filt_sum  = {filt_q, 1'b0} + {1'b0, filt_q} + {2'b00, batt_q};
  assign rise      = filt_q - oldest_q;
  assign fall      = oldest_q - filt_q;

  assign status_o.last      = last_q;
  assign status_o.due       = due_q;
  assign status_o.good_zero = (good_q == '0);
  assign status_o.div_last  = (dcnt_q == bvft_pkg::DCNT_W'(SUM_W - 1));
  assign status_o.ring_full = (fill_q == FILL_W'(TREND_SLOTS));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_mv_o    = out_mv_q;
  assign out_chg_o   = out_chg_q;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q   <= 1'b0;
      factor_q    <= bvft_pkg::FACTOR_RST;
      thresh_q    <= bvft_pkg::THRESH_RST;
      sum_q       <= '0;
      good_q      <= '0;
      tries_q     <= '0;
      dcnt_q      <= '0;
      filt_q      <= '0;
      seeded_q    <= 1'b0;
      head_q      <= '0;
      fill_q      <= '0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bvft_pkg::CFG_NOMINAL: nominal_q <= cfg_data_i[0];
          bvft_pkg::CFG_FACTOR:  factor_q  <= cfg_data_i[bvft_pkg::FAC_W-1:0];
          bvft_pkg::CFG_THRESH:  thresh_q  <= cfg_data_i[bvft_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accum && (tries_q < CNT_W'(MAX_SAMPLES))) begin
        tries_q <= tries_q + 1'b1;
        if (ok_q) begin
          sum_q  <= sum_ext[SUM_W] ? bvft_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
          good_q <= good_q + 1'b1;
        end
      end
      if (cmd_i.clr_round || cmd_i.batt) begin
        sum_q   <= '0;
        good_q  <= '0;
        tries_q <= '0;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.filt) begin
        filt_q   <= seeded_q ? filt_sum[MV_W+1:2] : batt_q;
        seeded_q <= 1'b1;
      end
      if (cmd_i.push) begin
        head_q <= (head_q == HEAD_W'(TREND_SLOTS - 1)) ? '0 : head_q + 1'b1;
        if (fill_q < FILL_W'(TREND_SLOTS)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.cmp) begin
        if ((filt_q >= oldest_q) && (rise >= {{(MV_W - bvft_pkg::THR_W){1'b0}}, thresh_q})) begin
          chg_q <= 1'b1;
        end else if ((oldest_q >= filt_q)
                     && (fall >= {{(MV_W - bvft_pkg::THR_W){1'b0}}, thresh_q})) begin
          chg_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers and trend ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= item_i.sample_value;
      ok_q     <= item_i.sample_ok;
      last_q   <= item_i.last_of_round;
      due_q    <= item_i.trend_due;
    end
    if (cmd_i.mult) begin
      prod_q <= nominal_q ? ({{SMP_W{1'b0}}, sample_q}
                             * {{SMP_W{1'b0}}, bvft_pkg::NOMINAL_FULL_MV})
                          : {{SMP_W{1'b0}}, sample_q};
    end
    if (cmd_i.est) begin
      q0_q <= est_sum[PROD_W-1:SMP_W];
    end
    if (cmd_i.corr) begin
      if (!nominal_q) begin
        mv_q <= sample_q;
      end else if (corr_rem >= {{(SMP_W + 1){1'b0}}, bvft_pkg::FULL_CODE}) begin
        mv_q <= q0_q + 1'b1;
      end else begin
        mv_q <= q0_q;
      end
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? CNT_W'(div_shift - {1'b0, good_q}) : div_shift[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], div_ge};
    end
    if (cmd_i.batt) begin
      batt_q <= (batt_prod > BATT_W'(bvft_pkg::MV_MAX)) ? bvft_pkg::MV_MAX
                                                        : batt_prod[MV_W-1:0];
    end
    if (cmd_i.push) begin
      ring_q[head_q] <= filt_q;
    end
    if (cmd_i.read_old) begin
      oldest_q <= ring_q[head_q];
    end
    if (cmd_i.emit) begin
      out_mv_q  <= filt_q;
      out_chg_q <= chg_q;
    end
  end

endmodule

[hdl/battery_voltage_filter_trend.sv]
// Top level of the battery voltage filter with charging-trend detection.
// A request that does not end a round is scaled and accumulated before the next one is taken.
// A round-ending request with good samples runs the 16-step serial divider, then battery
// scaling, the filter and, when due, a trend push (and a compare once the ring is full);
// it emits once the result register is free. With no good samples: round cleared, no result.
// Reset (rst_ni, asynchronous, active low) clears counters, filter, trend state, result valid.
module battery_voltage_filter_trend #(
  parameter int unsigned MAX_SAMPLES = bvft_pkg::MAX_SAMPLES,
  parameter int unsigned TREND_SLOTS = bvft_pkg::TREND_SLOTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bvft_smp_if.sink  smp_i,
  bvft_res_if.source res_o,
  bvft_cfg_if.sink  cfg_i
);

  bvft_pkg::cmd_t      cmd;
  bvft_pkg::status_t   status;
  bvft_pkg::smp_item_t item;

  assign item.sample_value  = smp_i.sample_value;
  assign item.sample_ok     = smp_i.sample_ok;
  assign item.last_of_round = smp_i.last_of_round;
  assign item.trend_due     = smp_i.trend_due;

  assign cfg_i.ready = 1'b1;

  bvft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_ready_o (smp_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bvft_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .TREND_SLOTS (TREND_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_mv_o    (res_o.smooth_mv),
    .out_chg_o   (res_o.charging)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_i.valid && smp_i.ready |=> !smp_i.ready)
    else $error("request accepted while one is in flight");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!res_o.valid || res_o.ready))
    else $error("result overwritten before it was taken");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.emit))
    else $error("result raised without an emit");
`endif

endmodule
